// ----- hw/rtl/tbd_pkg.sv -----
// Shared types, constants and the half-to-single conversion for the dequantizer.
package tbd_pkg;

  localparam int LANES      = 8;
  localparam int LANE_IDX_W = $clog2(LANES);
  localparam int LANE_CNT_W = 4;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [2:0] FMT_F32  = 3'd0;
  localparam logic [2:0] FMT_F16  = 3'd1;
  localparam logic [2:0] FMT_BF16 = 3'd2;
  localparam logic [2:0] FMT_Q4_0 = 3'd3;
  localparam logic [2:0] FMT_Q8_0 = 3'd4;
  localparam logic [2:0] FMT_Q6_K = 3'd5;

  localparam logic [7:0] QB_HDR       = 8'd2;
  localparam logic [7:0] Q8_LAST_POS  = 8'd33;
  localparam logic [7:0] Q6_D_LO_POS  = 8'd208;
  localparam logic [7:0] Q6_LAST_POS  = 8'd209;
  localparam logic [7:0] Q6_BLOCK_LEN = 8'd210;
  localparam logic [7:0] Q6_HI_BASE   = 8'd128;
  localparam logic [7:0] Q6_SC_BASE   = 8'd192;
  localparam logic [7:0] Q6_LAST_ELEM = 8'd255;
  localparam logic [7:0] Q4_OFFSET    = 8'd8;
  localparam logic [7:0] Q6_OFFSET    = 8'd32;

  typedef enum logic [2:0] {
    JOB_NONE, JOB_RAW, JOB_SCALE, JOB_Q4, JOB_Q8, JOB_Q6K
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [31:0] val;
    logic        tend;
  } job_t;

  typedef enum logic [2:0] {
    TK_NONE, TK_ELEM, TK_RAW, TK_SD, TK_END
  } tk_kind_t;

  typedef struct packed {
    tk_kind_t    kind;
    logic        fin;
    logic [31:0] a;
    logic [7:0]  q;
  } mul_op_t;

  typedef struct packed {
    tk_kind_t    kind;
    logic        fin;
    logic [31:0] val;
  } mul_res_t;

  typedef struct packed {
    logic       we;
    logic [7:0] addr;
    logic [7:0] data;
  } st_wr_t;

  typedef struct packed {
    logic       en;
    logic [6:0] lo_addr;
    logic [5:0] hi_addr;
    logic [3:0] sc_addr;
  } st_rd_t;

  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] sc;
  } st_data_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_Q4HI, BK_Q6SC, BK_Q6SD, BK_Q6WT, BK_Q6EL, BK_Q6LS
  } bk_state_t;

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic       sgn;
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] p;
    logic [3:0] n;
    logic [9:0] mn;
    logic [7:0] e;
    logic [31:0] r;
    sgn = h[15];
    ex  = h[14:10];
    man = h[9:0];
    p   = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) p = 4'(i);
    end
    n  = 4'd10 - p;
    mn = man << n;
    e  = 8'd113 - 8'(n);
    if (ex == 5'd0) begin
      r = (man == 10'd0) ? {sgn, 31'd0} : {sgn, e, mn, 13'd0};
    end else if (ex == 5'd31) begin
      r = {sgn, 8'hFF, man, 13'd0};
    end else begin
      r = {sgn, 8'(ex) + 8'd112, man, 13'd0};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/tbd_front.sv -----
// Front end: byte intake, element assembly, block headers and job generation.
module tbd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_wdata,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_data_byte,
  input  logic          in_tensor_end,
  input  logic          q_full,
  output logic          q_push,
  output tbd_pkg::job_t q_job,
  output tbd_pkg::st_wr_t st_wr,
  input  logic          q6_done
);
  import tbd_pkg::*;

  logic [2:0]  fmt_r;
  logic [7:0]  pos_r, pos_nxt;
  logic [23:0] asm_r, asm_nxt;
  logic        busy_r, busy_nxt;
  logic        acc;
  logic [7:0]  rel;
  logic [3:0]  j;
  logic        blk_end;

  assign in_stall = q_full || ((fmt_r == FMT_Q6_K) && busy_r);
  assign acc      = in_valid && !in_stall;
  assign rel      = pos_r - QB_HDR;
  assign j        = rel[3:0];
  assign blk_end  = (j == 4'hF);

  always_comb begin
    pos_nxt    = pos_r;
    asm_nxt    = asm_r;
    busy_nxt   = busy_r && !q6_done;
    q_push     = 1'b0;
    q_job.kind = JOB_NONE;
    q_job.val  = 32'd0;
    q_job.tend = in_tensor_end;
    st_wr.we   = 1'b0;
    st_wr.addr = pos_r;
    st_wr.data = in_data_byte;
    if (acc) begin
      case (fmt_r)
        FMT_F32: begin
          if (pos_r[1:0] == 2'd3) begin
            q_push     = 1'b1;
            q_job.kind = JOB_RAW;
            q_job.val  = {in_data_byte, asm_r};
            pos_nxt    = 8'd0;
            asm_nxt    = 24'd0;
          end else begin
            asm_nxt[{pos_r[1:0], 3'b000} +: 8] = in_data_byte;
            pos_nxt = pos_r + 8'd1;
          end
        end
        FMT_F16, FMT_BF16: begin
          if (pos_r != 8'd0) begin
            q_push     = 1'b1;
            q_job.kind = JOB_RAW;
            q_job.val  = (fmt_r == FMT_F16) ? half_to_single({in_data_byte, asm_r[7:0]})
                                            : {in_data_byte, asm_r[7:0], 16'd0};
            pos_nxt    = 8'd0;
            asm_nxt    = 24'd0;
          end else begin
            asm_nxt[7:0] = in_data_byte;
            pos_nxt      = 8'd1;
          end
        end
        FMT_Q4_0, FMT_Q8_0: begin
          if (pos_r == 8'd0) begin
            asm_nxt[7:0] = in_data_byte;
            pos_nxt      = 8'd1;
          end else if (pos_r == 8'd1) begin
            q_push     = 1'b1;
            q_job.kind = JOB_SCALE;
            q_job.val  = half_to_single({in_data_byte, asm_r[7:0]});
            asm_nxt    = 24'd0;
            pos_nxt    = QB_HDR;
          end else if (fmt_r == FMT_Q4_0) begin
            q_push     = 1'b1;
            q_job.kind = JOB_Q4;
            q_job.val  = {19'd0, blk_end, j, in_data_byte};
            pos_nxt    = blk_end ? 8'd0 : pos_r + 8'd1;
          end else begin
            q_push     = 1'b1;
            q_job.kind = JOB_Q8;
            q_job.val  = {24'd0, in_data_byte};
            pos_nxt    = (pos_r >= Q8_LAST_POS) ? 8'd0 : pos_r + 8'd1;
          end
        end
        FMT_Q6_K: begin
          st_wr.we = (pos_r < Q6_BLOCK_LEN);
          if (pos_r == Q6_D_LO_POS) asm_nxt[7:0] = in_data_byte;
          if (pos_r >= Q6_LAST_POS) begin
            q_push     = 1'b1;
            q_job.kind = JOB_Q6K;
            q_job.val  = half_to_single({in_data_byte, asm_r[7:0]});
            busy_nxt   = 1'b1;
            pos_nxt    = 8'd0;
          end else begin
            pos_nxt = pos_r + 8'd1;
          end
        end
        default: begin
        end
      endcase
      if (in_tensor_end) begin
        q_push  = 1'b1;
        pos_nxt = 8'd0;
        asm_nxt = 24'd0;
      end
    end
    if (cfg_we) begin
      pos_nxt = 8'd0;
      asm_nxt = 24'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r  <= FMT_F32;
      pos_r  <= 8'd0;
      asm_r  <= 24'd0;
      busy_r <= 1'b0;
    end else begin
      if (cfg_we) fmt_r <= cfg_wdata;
      pos_r  <= pos_nxt;
      asm_r  <= asm_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

// ----- hw/rtl/tbd_fifo.sv -----
// Job queue between the front end and the back end.
module tbd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tbd_pkg::job_t push_job,
  input  logic          pop,
  output tbd_pkg::job_t head,
  output logic          full,
  output logic          empty
);
  import tbd_pkg::*;

  job_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_r, rd_r;
  logic [FIFO_CW-1:0] cnt_r;
  logic               do_push, do_pop;

  assign full    = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + FIFO_CW'(do_push) - FIFO_CW'(do_pop);
    end
  end

endmodule

// ----- hw/rtl/tbd_q6_store.sv -----
// Q6_K block store: low nibbles, high bit pairs and sub-scales.
module tbd_q6_store (
  input  logic              clk,
  input  tbd_pkg::st_wr_t   wr,
  input  tbd_pkg::st_rd_t   rd,
  output tbd_pkg::st_data_t rdata
);
  import tbd_pkg::*;

  logic [7:0] lo_mem [128];
  logic [7:0] hi_mem [64];
  logic [7:0] sc_mem [16];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      if (wr.addr < Q6_HI_BASE) begin
        lo_mem[wr.addr[6:0]] <= wr.data;
      end else if (wr.addr < Q6_SC_BASE) begin
        hi_mem[wr.addr[5:0]] <= wr.data;
      end else if (wr.addr < Q6_D_LO_POS) begin
        sc_mem[wr.addr[3:0]] <= wr.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata.lo <= lo_mem[rd.lo_addr];
      rdata.hi <= hi_mem[rd.hi_addr];
      rdata.sc <= sc_mem[rd.sc_addr];
    end
  end

endmodule

// ----- hw/rtl/tbd_fmul.sv -----
// Two-stage fp32 by small-integer multiplier with round to nearest even.
module tbd_fmul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  tbd_pkg::mul_op_t  op,
  output tbd_pkg::mul_res_t res
);
  import tbd_pkg::*;

  tk_kind_t    k1_r, k2_r;
  logic        f1_r, f2_r;
  logic        sp1_r;
  logic [31:0] spv1_r;
  logic        s1_r;
  logic [7:0]  e1_r;
  logic [31:0] p1_r;
  logic [31:0] v2_r;

  logic [7:0]  mag;
  logic [31:0] prod;
  logic        spec;
  logic [31:0] specv;
  logic        a_nan, a_inf, a_zero;

  logic [3:0]  sh;
  logic [31:0] lowmask, dropped, halfv, mant;
  logic        rup;
  logic [24:0] m25;
  logic [7:0]  eo;
  logic [31:0] val;

  always_comb begin
    mag    = op.q[7] ? (~op.q + 8'd1) : op.q;
    prod   = {1'b1, op.a[22:0]} * mag;
    a_nan  = (op.a[30:23] == 8'hFF) && (op.a[22:0] != 23'd0);
    a_inf  = (op.a[30:23] == 8'hFF) && (op.a[22:0] == 23'd0);
    a_zero = (op.a[30:23] == 8'd0) || (op.q == 8'd0);
    spec   = 1'b1;
    specv  = op.a;
    if (op.kind == TK_ELEM || op.kind == TK_SD) begin
      if (a_nan) begin
        specv = {op.a[31:23], 1'b1, op.a[21:0]};
      end else if (a_inf) begin
        specv = (op.q == 8'd0) ? 32'hFFC0_0000 : {op.a[31] ^ op.q[7], 8'hFF, 23'd0};
      end else if (a_zero) begin
        specv = {op.a[31] ^ op.q[7], 31'd0};
      end else begin
        spec = 1'b0;
      end
    end
  end

  always_comb begin
    sh = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (p1_r[23 + i]) sh = 4'(i);
    end
    lowmask = (32'd1 << sh) - 32'd1;
    dropped = p1_r & lowmask;
    halfv   = (32'd1 << sh) >> 1;
    mant    = p1_r >> sh;
    rup     = (sh != 4'd0) && ((dropped > halfv) || ((dropped == halfv) && mant[0]));
    m25     = {1'b0, mant[23:0]} + 25'(rup);
    eo      = e1_r + 8'(sh) + 8'(m25[24]);
    val     = sp1_r ? spv1_r : {s1_r, eo, (m25[24] ? 23'd0 : m25[22:0])};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_r <= TK_NONE;
      k2_r <= TK_NONE;
    end else if (en) begin
      k1_r <= op.kind;
      k2_r <= k1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r   <= op.fin;
      sp1_r  <= spec;
      spv1_r <= specv;
      s1_r   <= op.a[31] ^ op.q[7];
      e1_r   <= op.a[30:23];
      p1_r   <= prod;
      f2_r   <= f1_r;
      v2_r   <= val;
    end
  end

  assign res.kind = k2_r;
  assign res.fin  = f2_r;
  assign res.val  = v2_r;

endmodule

// ----- hw/rtl/tbd_back.sv -----
// Back end: job sequencer, multiplier, lane packer and output register.
module tbd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  tbd_pkg::job_t     q_head,
  output logic              q_pop,
  output tbd_pkg::st_rd_t   st_rd,
  input  tbd_pkg::st_data_t st_data,
  output logic              q6_done,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_lane [tbd_pkg::LANES],
  output logic [tbd_pkg::LANE_CNT_W-1:0] out_lanes_valid,
  output logic              out_final_result
);
  import tbd_pkg::*;

  bk_state_t   state_r, state_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  idx_d_r, idx_d_nxt;
  logic        rd_vld_r, rd_vld_nxt;
  logic        end_r, end_nxt;
  logic [31:0] d_r, d_nxt;
  logic [31:0] scale_r, scale_nxt;
  logic [31:0] sd_r, sd_nxt;
  logic        sd_busy_r, sd_busy_nxt;
  logic [7:0]  q4buf_r [16];
  logic        q4_we;
  logic [7:0]  q4_rd;
  logic [31:0] pend_r [LANES];
  logic [31:0] pend_nxt [LANES];
  logic [31:0] grp [LANES];
  logic [LANE_CNT_W-1:0] pcnt_r, pcnt_nxt, cnt1;
  logic        emit, emit_fin;
  logic [LANE_CNT_W-1:0] emit_cnt;
  logic        out_valid_r;
  logic [31:0] out_lane_r [LANES];
  logic [LANE_CNT_W-1:0] out_cnt_r;
  logic        out_fin_r;
  logic        en;
  mul_op_t     op;
  mul_res_t    res;
  logic [3:0]  low4;
  logic [7:0]  hsh;
  logic [7:0]  q6q;

  assign en = !(out_valid_r && out_stall);

  tbd_fmul u_fmul (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .op    (op),
    .res   (res)
  );

  assign st_rd.en      = en;
  assign st_rd.lo_addr = cnt_r[7:1];
  assign st_rd.hi_addr = cnt_r[7:2];
  assign st_rd.sc_addr = cnt_r[7:4];

  assign low4  = idx_d_r[0] ? st_data.lo[7:4] : st_data.lo[3:0];
  assign hsh   = st_data.hi >> {idx_d_r[1:0], 1'b0};
  assign q6q   = {2'b00, hsh[1:0], low4} - Q6_OFFSET;
  assign q4_rd = q4buf_r[cnt_r[3:0]];

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    idx_d_nxt   = idx_d_r;
    rd_vld_nxt  = rd_vld_r;
    end_nxt     = end_r;
    d_nxt       = d_r;
    scale_nxt   = scale_r;
    sd_busy_nxt = sd_busy_r && (res.kind != TK_SD);
    q_pop       = 1'b0;
    q6_done     = 1'b0;
    q4_we       = 1'b0;
    op.kind     = TK_NONE;
    op.fin      = 1'b0;
    op.a        = 32'd0;
    op.q        = 8'd0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty && en) begin
          q_pop = 1'b1;
          case (q_head.kind)
            JOB_RAW: begin
              op.kind = TK_RAW;
              op.a    = q_head.val;
              op.fin  = q_head.tend;
            end
            JOB_SCALE: begin
              scale_nxt = q_head.val;
              op.kind   = q_head.tend ? TK_END : TK_NONE;
              op.fin    = q_head.tend;
            end
            JOB_Q8: begin
              op.kind = TK_ELEM;
              op.a    = scale_r;
              op.q    = q_head.val[7:0];
              op.fin  = q_head.tend;
            end
            JOB_Q4: begin
              q4_we   = 1'b1;
              op.kind = TK_ELEM;
              op.a    = scale_r;
              op.q    = {4'd0, q_head.val[3:0]} - Q4_OFFSET;
              op.fin  = q_head.tend && !q_head.val[12];
              if (q_head.val[12]) begin
                end_nxt   = q_head.tend;
                cnt_nxt   = 8'd0;
                state_nxt = BK_Q4HI;
              end
            end
            JOB_Q6K: begin
              d_nxt      = q_head.val;
              end_nxt    = q_head.tend;
              cnt_nxt    = 8'd0;
              rd_vld_nxt = 1'b0;
              state_nxt  = BK_Q6SC;
            end
            default: begin
              op.kind = q_head.tend ? TK_END : TK_NONE;
              op.fin  = q_head.tend;
            end
          endcase
        end
      end
      BK_Q4HI: begin
        op.kind = TK_ELEM;
        op.a    = scale_r;
        op.q    = {4'd0, q4_rd[7:4]} - Q4_OFFSET;
        op.fin  = end_r && (cnt_r[3:0] == 4'hF);
        cnt_nxt = cnt_r + 8'd1;
        if (cnt_r[3:0] == 4'hF) state_nxt = BK_IDLE;
      end
      BK_Q6SC: begin
        state_nxt = BK_Q6SD;
      end
      BK_Q6SD: begin
        op.kind     = TK_SD;
        op.a        = d_r;
        op.q        = st_data.sc;
        sd_busy_nxt = 1'b1;
        state_nxt   = BK_Q6WT;
      end
      BK_Q6WT: begin
        if (!sd_busy_r) state_nxt = BK_Q6EL;
      end
      BK_Q6EL: begin
        if (rd_vld_r) begin
          op.kind = TK_ELEM;
          op.a    = sd_r;
          op.q    = q6q;
        end
        rd_vld_nxt = 1'b1;
        idx_d_nxt  = cnt_r;
        cnt_nxt    = cnt_r + 8'd1;
        if (cnt_r[3:0] == 4'hF) state_nxt = BK_Q6LS;
      end
      BK_Q6LS: begin
        op.kind    = TK_ELEM;
        op.a       = sd_r;
        op.q       = q6q;
        op.fin     = end_r && (idx_d_r == Q6_LAST_ELEM);
        rd_vld_nxt = 1'b0;
        if (idx_d_r == Q6_LAST_ELEM) begin
          q6_done   = en;
          state_nxt = BK_IDLE;
        end else begin
          state_nxt = BK_Q6SC;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    sd_nxt   = sd_r;
    pcnt_nxt = pcnt_r;
    emit     = 1'b0;
    emit_fin = 1'b0;
    emit_cnt = pcnt_r;
    cnt1     = pcnt_r + 1'b1;
    grp      = pend_r;
    pend_nxt = pend_r;
    case (res.kind)
      TK_SD: sd_nxt = res.val;
      TK_ELEM, TK_RAW: begin
        grp[pcnt_r[LANE_IDX_W-1:0]] = res.val;
        if ((cnt1 == LANE_CNT_W'(LANES)) || res.fin) begin
          emit     = 1'b1;
          emit_fin = res.fin;
          emit_cnt = cnt1;
          pcnt_nxt = '0;
          for (int i = 0; i < LANES; i++) pend_nxt[i] = 32'd0;
        end else begin
          pcnt_nxt = cnt1;
          pend_nxt = grp;
        end
      end
      TK_END: begin
        emit     = 1'b1;
        emit_fin = 1'b1;
        pcnt_nxt = '0;
        for (int i = 0; i < LANES; i++) pend_nxt[i] = 32'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= 8'd0;
      rd_vld_r    <= 1'b0;
      sd_busy_r   <= 1'b0;
      scale_r     <= 32'd0;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LANES; i++) pend_r[i] <= 32'd0;
    end else if (en) begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      sd_busy_r   <= sd_busy_nxt;
      scale_r     <= scale_nxt;
      pcnt_r      <= pcnt_nxt;
      out_valid_r <= emit;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_d_r <= idx_d_nxt;
      end_r   <= end_nxt;
      d_r     <= d_nxt;
      sd_r    <= sd_nxt;
      if (q4_we) q4buf_r[q_head.val[11:8]] <= q_head.val[7:0];
      if (emit) begin
        out_lane_r <= grp;
        out_cnt_r  <= emit_cnt;
        out_fin_r  <= emit_fin;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_lane         = out_lane_r;
  assign out_lanes_valid  = out_cnt_r;
  assign out_final_result = out_fin_r;

`ifndef SYNTH
  a_sd_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_Q6EL) |-> !sd_busy_r)
    else $error("element issued before sub-block scale settled");
  a_pcnt: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r < LANE_CNT_W'(LANES))
    else $error("partial group overflow");
  a_empty_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_cnt_r == '0)) |-> out_fin_r)
    else $error("empty word without final flag");
  a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
    q6_done |-> (state_r == BK_Q6LS) && (idx_d_r == Q6_LAST_ELEM))
    else $error("block done outside last element");
`endif

endmodule

// ----- hw/rtl/tensor_block_dequantizer.sv -----
// Top level of the tensor block dequantizer.
// Usage: write the 3-bit format through cfg_we/cfg_wdata while idle
// (0 F32, 1 F16, 2 BF16, 3 Q4_0, 4 Q8_0, 5 Q6_K). Stream the tensor one byte
// per input word on in_valid/in_stall, in_tensor_end set on the last byte.
// Each output word carries up to eight fp32 lanes, out_lanes_valid counting
// from lane 0, and out_final_result on the tensor's last word.
// A byte that completes an element passes through the job queue, both
// multiplier stages and the output register; its lane leaves with its word
// once the word is full or the tensor ends. F32, F16, BF16 and Q8_0 take
// one byte per cycle while the job queue is not full. Q4_0 holds input,
// once the queue fills, while the high nibbles of an 18-byte block are
// issued. Q6_K takes a 210-byte block at one byte per cycle while the queue
// is not full, then holds input while the 256 elements leave the single
// multiplier (16 sub-blocks, each a scale product, a wait and 16 elements).
// Reset clears the format to F32, the block scale, the byte assembly and
// pending lanes. A stalled output holds the back end; the four-entry job
// queue keeps the front end taking bytes until full, then in_stall rises.
module tensor_block_dequantizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_tensor_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_lane0,
  output logic [31:0] out_lane1,
  output logic [31:0] out_lane2,
  output logic [31:0] out_lane3,
  output logic [31:0] out_lane4,
  output logic [31:0] out_lane5,
  output logic [31:0] out_lane6,
  output logic [31:0] out_lane7,
  output logic [3:0]  out_lanes_valid,
  output logic        out_final_result
);
  import tbd_pkg::*;

  logic      q_full, q_empty, q_push, q_pop, q6_done;
  job_t      push_job, head_job;
  st_wr_t    st_wr;
  st_rd_t    st_rd;
  st_data_t  st_data;
  logic [31:0] lanes [LANES];

  tbd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_tensor_end (in_tensor_end),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (push_job),
    .st_wr         (st_wr),
    .q6_done       (q6_done)
  );

  tbd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  tbd_q6_store u_store (
    .clk   (clk),
    .wr    (st_wr),
    .rd    (st_rd),
    .rdata (st_data)
  );

  tbd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (head_job),
    .q_pop            (q_pop),
    .st_rd            (st_rd),
    .st_data          (st_data),
    .q6_done          (q6_done),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_lane         (lanes),
    .out_lanes_valid  (out_lanes_valid),
    .out_final_result (out_final_result)
  );

  assign out_lane0 = lanes[0];
  assign out_lane1 = lanes[1];
  assign out_lane2 = lanes[2];
  assign out_lane3 = lanes[3];
  assign out_lane4 = lanes[4];
  assign out_lane5 = lanes[5];
  assign out_lane6 = lanes[6];
  assign out_lane7 = lanes[7];

endmodule

// ----- verif/tb_tensor_block_dequantizer.sv -----
// Testbench for the tensor block dequantizer: bit-exact fp32 prediction, random stalls.
module tb_tensor_block_dequantizer;
  import tbd_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       tend;
  } byte_item_t;

  typedef struct {
    logic [31:0] lane [8];
    logic [3:0]  nv;
    logic        fin;
  } lane_word_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_tensor_end;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_lane [8];
  logic [3:0]  out_lanes_valid;
  logic        out_final_result;

  byte_item_t  byte_q[$];
  lane_word_t  expected_words[$];
  logic [31:0] elem_fifo[$];

  logic [2:0]  cur_fmt;
  int          byte_pos;
  logic [31:0] assembly;
  logic [31:0] scale_bits;
  logic [7:0]  blk [210];

  int mismatches;
  int words_seen;
  int bytes_taken;
  int cycles;
  int burst_left;
  int gap_left;
  int hold_left;
  int stall_phase;
  int stall_mode;
  bit hold_req;

  tensor_block_dequantizer uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_byte(in_data_byte),
    .in_tensor_end(in_tensor_end), .out_valid(out_valid), .out_stall(out_stall),
    .out_lane0(out_lane[0]), .out_lane1(out_lane[1]), .out_lane2(out_lane[2]),
    .out_lane3(out_lane[3]), .out_lane4(out_lane[4]), .out_lane5(out_lane[5]),
    .out_lane6(out_lane[6]), .out_lane7(out_lane[7]),
    .out_lanes_valid(out_lanes_valid), .out_final_result(out_final_result)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [10:0] mm;
    int          e;
    mm = {1'b0, h[9:0]};
    e = h[14:10];
    if (e == 31) return {h[15], 8'hFF, h[9:0], 13'd0};
    if (e == 0) begin
      if (mm == 0) return {h[15], 31'd0};
      e = 113;
      while (!mm[10]) begin
        mm = mm << 1;
        e--;
      end
      return {h[15], 8'(e), mm[9:0], 13'd0};
    end
    return {h[15], 8'(e + 112), h[9:0], 13'd0};
  endfunction

  function automatic logic [31:0] int_to_single(input int q);
    int          mag;
    int          top;
    logic [31:0] m;
    if (q == 0) return 32'd0;
    mag = (q < 0) ? -q : q;
    top = 0;
    for (int i = 0; i < 31; i++) if (mag[i]) top = i;
    m = 32'(mag) << (23 - top);
    return {q < 0, 8'(127 + top), m[22:0]};
  endfunction

  function automatic logic [31:0] single_mul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [24:0] m;
    logic [31:0] r;
    logic        sg;
    logic        g;
    logic        st;
    int          ea;
    int          eb;
    int          e;
    int          sh;
    sg = a[31] ^ b[31];
    if (a[30:23] == 8'hFF && a[22:0] != 0) return a | 32'h0040_0000;
    if (b[30:23] == 8'hFF && b[22:0] != 0) return b | 32'h0040_0000;
    if (a[30:23] == 8'hFF) return (b[30:0] == 0) ? 32'hFFC0_0000 : {sg, 31'h7F80_0000};
    if (b[30:23] == 8'hFF) return (a[30:0] == 0) ? 32'hFFC0_0000 : {sg, 31'h7F80_0000};
    if (a[30:0] == 0 || b[30:0] == 0) return {sg, 31'd0};
    ea = a[30:23];
    ma = {ea != 0, a[22:0]};
    if (ea == 0) ea = 1;
    while (!ma[23]) begin
      ma = ma << 1;
      ea--;
    end
    eb = b[30:23];
    mb = {eb != 0, b[22:0]};
    if (eb == 0) eb = 1;
    while (!mb[23]) begin
      mb = mb << 1;
      eb--;
    end
    p = 64'(ma) * 64'(mb);
    e = ea + eb - 127;
    if (p[47]) e++;
    else p = p << 1;
    if (e <= 0) begin
      sh = 1 - e;
      if (sh > 50) sh = 50;
      st = |(p & ((64'd1 << sh) - 64'd1));
      p = p >> sh;
      p[0] = p[0] | st;
      e = 0;
    end
    m = {1'b0, p[47:24]};
    g = p[23];
    st = |p[22:0];
    if (g && (st || m[0])) m = m + 25'd1;
    if (e == 0) r = 32'(m);
    else r = (32'(e - 1) << 23) + 32'(m);
    if (r >= 32'h7F80_0000) r = 32'h7F80_0000;
    return {sg, r[30:0]};
  endfunction

  task automatic emit_lanes(input bit tensor_done);
    lane_word_t w;
    bit         closed;
    closed = 1'b0;
    while (elem_fifo.size() >= LANES) begin
      for (int i = 0; i < 8; i++) w.lane[i] = elem_fifo.pop_front();
      w.nv = 4'd8;
      w.fin = tensor_done && elem_fifo.size() == 0;
      if (w.fin) closed = 1'b1;
      expected_words.insert(expected_words.size(), w);
    end
    if (tensor_done && !closed) begin
      w.nv = 4'(elem_fifo.size());
      for (int i = 0; i < 8; i++) w.lane[i] = (i < w.nv) ? elem_fifo[i] : 32'd0;
      elem_fifo.delete();
      w.fin = 1'b1;
      expected_words.insert(expected_words.size(), w);
    end
  endtask

  task automatic decode_q6_block();
    logic [31:0] d;
    logic [31:0] sd;
    logic [7:0]  lb;
    logic [3:0]  lo4;
    logic [1:0]  hi2;
    int          idx;
    d = widen_half({blk[209], blk[208]});
    for (int k = 0; k < 16; k++) begin
      sd = single_mul(d, int_to_single(int'($signed(blk[192 + k]))));
      for (int i = 0; i < 16; i++) begin
        idx = k * 16 + i;
        lb = blk[idx >> 1];
        lo4 = idx[0] ? lb[7:4] : lb[3:0];
        hi2 = 2'(blk[128 + (idx >> 2)] >> ((idx & 3) * 2));
        elem_fifo.insert(elem_fifo.size(),
                         single_mul(sd, int_to_single(int'({hi2, lo4}) - 32)));
      end
    end
  endtask

  task automatic dequant_byte(input logic [7:0] b, input logic tend);
    int j;
    case (cur_fmt)
      FMT_F32: begin
        assembly = assembly | (32'(b) << (8 * (byte_pos & 3)));
        if (byte_pos >= 3) begin
          elem_fifo.insert(elem_fifo.size(), assembly);
          assembly = 0;
          byte_pos = 0;
        end else byte_pos++;
      end
      FMT_F16, FMT_BF16: begin
        assembly = assembly | (32'(b) << (8 * (byte_pos & 1)));
        if (byte_pos >= 1) begin
          elem_fifo.insert(elem_fifo.size(),
                           cur_fmt == FMT_F16 ? widen_half(assembly[15:0])
                                              : {assembly[15:0], 16'd0});
          assembly = 0;
          byte_pos = 0;
        end else byte_pos++;
      end
      FMT_Q4_0, FMT_Q8_0: begin
        if (byte_pos < 2) begin
          assembly = assembly | (32'(b) << (8 * byte_pos));
          if (byte_pos == 1) begin
            scale_bits = widen_half(assembly[15:0]);
            assembly = 0;
          end
          byte_pos++;
        end else if (cur_fmt == FMT_Q4_0) begin
          j = (byte_pos - 2) & 15;
          blk[j] = b;
          elem_fifo.insert(elem_fifo.size(),
                           single_mul(scale_bits, int_to_single(int'(b[3:0]) - 8)));
          if (j == 15) begin
            for (int m = 0; m < 16; m++)
              elem_fifo.insert(elem_fifo.size(),
                               single_mul(scale_bits,
                                          int_to_single(int'(blk[m][7:4]) - 8)));
            byte_pos = 0;
          end else byte_pos++;
        end else begin
          elem_fifo.insert(elem_fifo.size(),
                           single_mul(scale_bits, int_to_single(int'($signed(b)))));
          byte_pos = (byte_pos >= 33) ? 0 : byte_pos + 1;
        end
      end
      FMT_Q6_K: begin
        blk[byte_pos] = b;
        if (byte_pos >= 209) begin
          decode_q6_block();
          byte_pos = 0;
        end else byte_pos++;
      end
      default: ;
    endcase
    if (tend) begin
      byte_pos = 0;
      assembly = 0;
    end
    emit_lanes(tend);
  endtask

  // sender: bursts with random gaps, payload held while stalled
  always @(posedge clk) begin
    byte_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'd0;
      in_tensor_end <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        dequant_byte(in_data_byte, in_tensor_end);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          it = byte_q.pop_front();
          in_data_byte <= it.data;
          in_tensor_end <= it.tend;
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern picked at random from four modes, one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      stall_phase = 0;
      stall_mode = 0;
    end else begin
      stall_phase++;
      if (stall_phase % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_req && hold_left == 0) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= $urandom_range(0, 1);
          2: out_stall <= (stall_phase % 5) < 2;
          default: out_stall <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    lane_word_t w;
    bit         bad;
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output word: lanes_valid %0d final %0b",
                   out_lanes_valid, out_final_result);
      end else begin
        w = expected_words.pop_front();
        bad = (out_lanes_valid !== w.nv) || (out_final_result !== w.fin);
        for (int i = 0; i < 8; i++) if (out_lane[i] !== w.lane[i]) bad = 1'b1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("word %0d mismatch: lanes_valid exp %0d got %0d, final exp %0b got %0b",
                     words_seen, w.nv, out_lanes_valid, w.fin, out_final_result);
            for (int i = 0; i < 8; i++)
              if (out_lane[i] !== w.lane[i])
                $display("  lane%0d exp %h got %h", i, w.lane[i], out_lane[i]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("timeout with %0d words outstanding", expected_words.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic tend);
    byte_item_t it;
    it.data = b;
    it.tend = tend;
    byte_q.insert(byte_q.size(), it);
  endtask

  task automatic add_half(input logic [15:0] h);
    add_byte(h[7:0], 1'b0);
    add_byte(h[15:8], 1'b0);
  endtask

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 11))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7C00;
      3: return 16'hFC00;
      4: return 16'h7E01;
      5: return 16'h0001;
      6: return 16'h83FF;
      7: return 16'h7BFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // one tensor of format fmt; any tail bytes mostly leave an element or block open
  task automatic add_tensor(input logic [2:0] fmt, input int units);
    int tail;
    int ebytes;
    for (int u = 0; u < units; u++) begin
      case (fmt)
        FMT_Q4_0, FMT_Q8_0: begin
          add_half(pick_scale());
          for (int i = 0; i < ((fmt == FMT_Q4_0) ? 16 : 32); i++) add_byte(8'($urandom), 1'b0);
        end
        FMT_Q6_K: begin
          for (int i = 0; i < 208; i++) add_byte(8'($urandom), 1'b0);
          add_half(16'($urandom_range(0, 16'h5BFF)) | (16'($urandom_range(0, 1)) << 15));
        end
        default: begin
          ebytes = (fmt == FMT_F32) ? 4 : 2;
          for (int i = 0; i < ebytes; i++) add_byte(8'($urandom), 1'b0);
        end
      endcase
    end
    tail = ($urandom_range(0, 2) == 0) ? $urandom_range(1, (fmt == FMT_F32) ? 3 : 1) : 0;
    if (fmt >= FMT_Q4_0 && tail > 0) tail = $urandom_range(1, 20);
    for (int i = 0; i < tail; i++) add_byte(8'($urandom), 1'b0);
    if (byte_q.size() == 0) add_byte(8'($urandom), 1'b1);
    else byte_q[byte_q.size() - 1].tend = 1'b1;
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || in_valid || expected_words.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_format(input logic [2:0] fmt);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= fmt;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_fmt = fmt;
    byte_pos = 0;
    assembly = 0;
  endtask

  initial begin
    logic [2:0] plan [9];
    int         target;
    plan = '{FMT_F32, FMT_F16, FMT_BF16, FMT_Q4_0, FMT_Q8_0, FMT_Q6_K, FMT_BF16,
             FMT_Q4_0, FMT_F32};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = FMT_F32;
    hold_req = 1'b0;
    cur_fmt = FMT_F32;
    byte_pos = 0;
    assembly = 0;
    scale_bits = 0;
    mismatches = 0;
    words_seen = 0;
    bytes_taken = 0;
    cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (plan[p]) begin
      write_format(plan[p]);
      if (p == 0) begin
        add_byte(8'hFF, 1'b1);
        for (int i = 0; i < 4; i++) add_byte(8'hFF, 1'b0);
        for (int i = 0; i < 4; i++) add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b1);
      end else if (p == 1) begin
        add_half(16'h0001);
        add_half(16'h03FF);
        add_half(16'h7C00);
        add_half(16'hFE01);
        add_half(16'h8000);
        add_byte(8'h00, 1'b1);
      end
      if (plan[p] == FMT_Q8_0 || plan[p] == FMT_Q6_K) hold_req = 1'b1;
      target = byte_q.size() + ((plan[p] == FMT_Q6_K) ? 1 : 12);
      while (byte_q.size() < target)
        add_tensor(plan[p], (plan[p] >= FMT_Q4_0) ? 1 : $urandom_range(1, 4));
      wait_drained();
    end
    $display("Ran %0d bytes through all six formats, checked %0d output words.",
             bytes_taken, words_seen);
    $display("Stalls mixed random receiver patterns with long hold-offs in Q8_0 and Q6_K.");
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/tbd_pkg.sv
hw/rtl/tbd_front.sv
hw/rtl/tbd_fifo.sv
hw/rtl/tbd_q6_store.sv
hw/rtl/tbd_fmul.sv
hw/rtl/tbd_back.sv
hw/rtl/tensor_block_dequantizer.sv
verif/tb_tensor_block_dequantizer.sv
